// ----- hw/rtl/vcp_pkg.sv -----
// Shared widths, fixed-point constants and register codes for the vertex color packer.
package vcp_pkg;

    localparam int POS_W  = 24;
    localparam int COL_W  = 16;
    localparam int CNT_W  = 13;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] MAX_VERTICES = 13'd4096;
    localparam logic [CNT_W-1:0] LIMIT_RESET  = 13'd4096;

    localparam logic [COL_W-1:0] ONE_Q15     = 16'd32768;
    localparam logic [MUL_W-1:0] GAIN_Q15    = 17'd45875;
    localparam logic [MUL_W-1:0] SAT_Q15     = 17'd26214;
    localparam logic [MUL_W-1:0] ONE_MINUS_S = 17'd6554;
    localparam logic [MUL_W-1:0] ONE_TURN    = 17'd65536;

    // Register index, taken from paddr[2]
    localparam logic REG_VERTEX_LIMIT = 1'b0;

endpackage

// ----- hw/rtl/vcp_if.sv -----
// Valid/ready channel interfaces for particles in and vertices out.
interface vcp_particle_if;
    import vcp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x_in;
    logic signed [POS_W-1:0] pos_y_in;
    logic        [COL_W-1:0] hue;
    logic        [COL_W-1:0] life;
    logic                    last_particle;

    modport source (output valid, pos_x_in, pos_y_in, hue, life, last_particle,
                    input ready);
    modport sink   (input valid, pos_x_in, pos_y_in, hue, life, last_particle,
                    output ready);
endinterface

interface vcp_vertex_if;
    import vcp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x_out;
    logic signed [POS_W-1:0] pos_y_out;
    logic        [COL_W-1:0] red;
    logic        [COL_W-1:0] green;
    logic        [COL_W-1:0] blue;
    logic        [COL_W-1:0] alpha;
    logic                    last_vertex;
    logic        [CNT_W-1:0] vertices_written;

    modport source (output valid, pos_x_out, pos_y_out, red, green, blue, alpha,
                    last_vertex, vertices_written, input ready);
    modport sink   (input valid, pos_x_out, pos_y_out, red, green, blue, alpha,
                    last_vertex, vertices_written, output ready);
endinterface

// ----- hw/rtl/vcp_cfg.sv -----
// APB register block holding the per-frame vertex limit.
module vcp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcp_pkg::APB_AW-1:0]    paddr,
    input  logic [vcp_pkg::APB_DW-1:0]    pwdata,
    output logic [vcp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [vcp_pkg::CNT_W-1:0]     vertex_limit
);
    import vcp_pkg::*;

    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_VERTEX_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en)
        begin
            limit_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_VERTEX_LIMIT)
        begin
            prdata = {{(APB_DW-CNT_W){1'b0}}, limit_reg};
        end
    end

    assign vertex_limit = limit_reg;

endmodule

// ----- hw/rtl/vcp_mul.sv -----
// Shared 17x17 unsigned multiplier with a registered product.
module vcp_mul (
    input  logic                          clk,
    input  logic [vcp_pkg::MUL_W-1:0]     op_a,
    input  logic [vcp_pkg::MUL_W-1:0]     op_b,
    output logic [vcp_pkg::PROD_W-1:0]    prod
);
    import vcp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/vcp_core.sv -----
// Sequencer: frame counter, operand selection for the shared multiplier, color assembly.
module vcp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vcp_pkg::CNT_W-1:0]     vertex_limit,
    vcp_particle_if.sink                  particle,
    vcp_vertex_if.source                  vertex,
    output logic [vcp_pkg::MUL_W-1:0]     op_a,
    output logic [vcp_pkg::MUL_W-1:0]     op_b,
    input  logic [vcp_pkg::PROD_W-1:0]    prod
);
    import vcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VAL,
        S_K1,
        S_K2,
        S_P,
        S_Q,
        S_T,
        S_DONE
    } state_t;

    state_t                  state_reg,  state_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [COL_W-1:0]        life_reg, frac_reg;
    logic [2:0]              sector_reg;
    logic                    last_reg;
    logic [CNT_W-1:0]        written_reg;
    logic [COL_W-1:0]        val_reg, k1_reg, k2_reg, p_reg, q_reg;

    logic signed [POS_W-1:0] out_x_reg, out_y_reg;
    logic [COL_W-1:0]        out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic                    out_last_reg;
    logic [CNT_W-1:0]        out_cnt_reg;

    logic [CNT_W-1:0]        limit_eff;
    logic                    accept;
    logic                    drop;
    logic [CNT_W-1:0]        count_inc;
    logic [18:0]             hh;
    logic [COL_W-1:0]        life_clamp;
    logic [18:0]             val_raw;
    logic [COL_W-1:0]        val_sat;
    logic [COL_W-1:0]        prod_q15;
    logic [COL_W-1:0]        t_val;
    logic [COL_W-1:0]        r_sel, g_sel, b_sel;
    logic                    load_out;

    assign limit_eff  = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    assign accept     = particle.valid && particle.ready;
    assign drop       = (count_reg >= limit_eff);
    assign count_inc  = count_reg + 1'b1;
    assign hh         = {1'b0, particle.hue, 2'b00} + {2'b00, particle.hue, 1'b0};
    assign life_clamp = (particle.life > ONE_Q15) ? ONE_Q15 : particle.life;

    assign val_raw    = prod[33:15];
    assign val_sat    = (val_raw > {3'b000, ONE_Q15}) ? ONE_Q15 : val_raw[COL_W-1:0];
    assign prod_q15   = prod[30:15];
    assign t_val      = prod_q15;

    assign particle.ready = (state_reg == S_IDLE);
    assign load_out       = (state_reg == S_DONE) && (!out_valid_reg || vertex.ready);

    // Operands for the registered product, which lands in the cycle after they are driven
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_VAL:
            begin
                op_a = {1'b0, life_reg};
                op_b = GAIN_Q15;
            end
            S_K1:
            begin
                op_a = {1'b0, frac_reg};
                op_b = SAT_Q15;
            end
            S_K2:
            begin
                op_a = ONE_TURN - {1'b0, frac_reg};
                op_b = SAT_Q15;
            end
            S_P:
            begin
                op_a = {1'b0, val_reg};
                op_b = ONE_MINUS_S;
            end
            S_Q:
            begin
                op_a = {1'b0, val_reg};
                op_b = {1'b0, k1_reg};
            end
            S_T, S_DONE:
            begin
                // hold operands in S_DONE so the t product stays put while stalled
                op_a = {1'b0, val_reg};
                op_b = {1'b0, k2_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        r_sel = val_reg;
        g_sel = p_reg;
        b_sel = q_reg;
        case (sector_reg)
            3'd0:
            begin
                r_sel = val_reg; g_sel = t_val;   b_sel = p_reg;
            end
            3'd1:
            begin
                r_sel = q_reg;   g_sel = val_reg; b_sel = p_reg;
            end
            3'd2:
            begin
                r_sel = p_reg;   g_sel = val_reg; b_sel = t_val;
            end
            3'd3:
            begin
                r_sel = p_reg;   g_sel = q_reg;   b_sel = val_reg;
            end
            3'd4:
            begin
                r_sel = t_val;   g_sel = p_reg;   b_sel = val_reg;
            end
            default:
            begin
                r_sel = val_reg; g_sel = p_reg;   b_sel = q_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (vertex.valid && vertex.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (drop)
                    begin
                        if (particle.last_particle)
                        begin
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        count_next = particle.last_particle ? '0 : count_inc;
                        state_next = S_VAL;
                    end
                end
            end
            S_VAL:  state_next = S_K1;
            S_K1:   state_next = S_K2;
            S_K2:   state_next = S_P;
            S_P:    state_next = S_Q;
            S_Q:    state_next = S_T;
            S_T:    state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && !drop)
        begin
            pos_x_reg   <= particle.pos_x_in;
            pos_y_reg   <= particle.pos_y_in;
            life_reg    <= life_clamp;
            sector_reg  <= hh[18:16];
            frac_reg    <= hh[15:0];
            last_reg    <= particle.last_particle;
            written_reg <= count_inc;
        end
        if (state_reg == S_K1)
        begin
            val_reg <= val_sat;
        end
        if (state_reg == S_K2)
        begin
            k1_reg <= ONE_Q15 - prod[31:16];
        end
        if (state_reg == S_P)
        begin
            k2_reg <= ONE_Q15 - prod[31:16];
        end
        if (state_reg == S_Q)
        begin
            p_reg <= prod_q15;
        end
        if (state_reg == S_T)
        begin
            q_reg <= prod_q15;
        end
        if (load_out)
        begin
            out_x_reg    <= pos_x_reg;
            out_y_reg    <= pos_y_reg;
            out_r_reg    <= r_sel;
            out_g_reg    <= g_sel;
            out_b_reg    <= b_sel;
            out_a_reg    <= life_reg;
            out_last_reg <= last_reg;
            out_cnt_reg  <= written_reg;
        end
    end

    assign vertex.valid            = out_valid_reg;
    assign vertex.pos_x_out        = out_x_reg;
    assign vertex.pos_y_out        = out_y_reg;
    assign vertex.red              = out_r_reg;
    assign vertex.green            = out_g_reg;
    assign vertex.blue             = out_b_reg;
    assign vertex.alpha            = out_a_reg;
    assign vertex.last_vertex      = out_last_reg;
    assign vertex.vertices_written = out_cnt_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_VERTICES)
        else $error("frame count above vertex cap");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !drop) |=> (state_reg == S_VAL))
        else $error("kept particle did not start the sequence");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drop) |=> (state_reg == S_IDLE))
        else $error("dropped particle left idle");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("vertex valid without finishing sequence");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> (vertex.red <= ONE_Q15 && vertex.green <= ONE_Q15
                          && vertex.blue <= ONE_Q15))
        else $error("color channel above one");

endmodule

// ----- hw/rtl/vertex_color_pack.sv -----
// Top level of the vertex color packer: APB config, sequencer and shared multiplier.
// A kept particle steps through S_VAL, S_K1, S_K2, S_P, S_Q, S_T and S_DONE; a dropped one stays in S_IDLE.
// A new particle is taken only in S_IDLE, after the six products through the one multiplier.
// The vertex output register frees the sequencer unless the sink stalls a second vertex.
// Reset (rst_n, async low): idle, frame count zero, no vertex pending, vertex_limit 4096.
module vertex_color_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcp_pkg::APB_AW-1:0]    paddr,
    input  logic [vcp_pkg::APB_DW-1:0]    pwdata,
    output logic [vcp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    vcp_particle_if.sink                  particle,
    vcp_vertex_if.source                  vertex
);
    import vcp_pkg::*;

    logic [CNT_W-1:0]  vertex_limit;
    logic [MUL_W-1:0]  op_a;
    logic [MUL_W-1:0]  op_b;
    logic [PROD_W-1:0] prod;

    vcp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_limit (vertex_limit)
    );

    vcp_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    vcp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_limit (vertex_limit),
        .particle     (particle),
        .vertex       (vertex),
        .op_a         (op_a),
        .op_b         (op_b),
        .prod         (prod)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vertex_color_pack: HSV color, position pass-through, frame limit.
module testbench;
    import vcp_pkg::*;

    localparam int unsigned Q15_ONE      = 32768;
    localparam int unsigned Q16_ONE      = 65536;
    localparam int unsigned SATURATION   = 26214;
    localparam int unsigned DESATURATION = 6554;
    localparam int unsigned VALUE_GAIN   = 45875;
    localparam int unsigned HUE_SECTORS  = 6;
    localparam int unsigned VERTEX_CAP   = 4096;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          ROUND_ITEMS  = 225;

    typedef enum int unsigned {
        HUE_RED,
        HUE_YELLOW,
        HUE_GREEN,
        HUE_CYAN,
        HUE_BLUE,
        HUE_MAGENTA
    } hue_sextant_t;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [COL_W-1:0] hue;
        logic        [COL_W-1:0] life;
        logic                    last;
    } particle_t;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [COL_W-1:0] red;
        logic        [COL_W-1:0] green;
        logic        [COL_W-1:0] blue;
        logic        [COL_W-1:0] alpha;
        logic                    last;
        logic        [CNT_W-1:0] written;
    } vertex_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    vcp_particle_if particle_ch ();
    vcp_vertex_if   vertex_ch ();

    vertex_color_pack u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .particle (particle_ch),
        .vertex   (vertex_ch)
    );

    vertex_t          expected_vertices[$];
    logic [CNT_W-1:0] vertex_limit_mirror = LIMIT_RESET;
    logic [CNT_W-1:0] frame_vertices      = '0;
    int               mismatch_count      = 0;
    int               sender_idle_pct     = 0;
    int               receiver_stall_pct  = 0;
    int               quiet_cycles        = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Color one particle and advance the frame count; returns 0 when it is dropped.
    function automatic bit shade_particle(input particle_t pt, output vertex_t vx);
        int unsigned  cap;
        int unsigned  life_q;
        int unsigned  value;
        int unsigned  scaled_hue;
        int unsigned  frac;
        int unsigned  p;
        int unsigned  q;
        int unsigned  t;
        hue_sextant_t sextant;

        cap = (32'(vertex_limit_mirror) > VERTEX_CAP) ? VERTEX_CAP : 32'(vertex_limit_mirror);
        vx = '{default: '0};
        if (32'(frame_vertices) >= cap)
        begin
            if (pt.last)
                frame_vertices = '0;
            return 1'b0;
        end
        frame_vertices = frame_vertices + 1'b1;

        life_q = (32'(pt.life) > Q15_ONE) ? Q15_ONE : 32'(pt.life);
        value = (life_q * VALUE_GAIN) >> 15;
        if (value > Q15_ONE)
            value = Q15_ONE;

        scaled_hue = 32'(pt.hue) * HUE_SECTORS;
        sextant = hue_sextant_t'(scaled_hue >> 16);
        frac = scaled_hue & (Q16_ONE - 1);
        p = (value * DESATURATION) >> 15;
        q = (value * (Q15_ONE - ((SATURATION * frac) >> 16))) >> 15;
        t = (value * (Q15_ONE - ((SATURATION * (Q16_ONE - frac)) >> 16))) >> 15;

        case (sextant)
            HUE_RED:
            begin
                vx.red = COL_W'(value); vx.green = COL_W'(t);     vx.blue = COL_W'(p);
            end
            HUE_YELLOW:
            begin
                vx.red = COL_W'(q);     vx.green = COL_W'(value); vx.blue = COL_W'(p);
            end
            HUE_GREEN:
            begin
                vx.red = COL_W'(p);     vx.green = COL_W'(value); vx.blue = COL_W'(t);
            end
            HUE_CYAN:
            begin
                vx.red = COL_W'(p);     vx.green = COL_W'(q);     vx.blue = COL_W'(value);
            end
            HUE_BLUE:
            begin
                vx.red = COL_W'(t);     vx.green = COL_W'(p);     vx.blue = COL_W'(value);
            end
            default:
            begin
                vx.red = COL_W'(value); vx.green = COL_W'(p);     vx.blue = COL_W'(q);
            end
        endcase

        vx.pos_x = pt.pos_x;
        vx.pos_y = pt.pos_y;
        vx.alpha = COL_W'(life_q);
        vx.last = pt.last;
        vx.written = frame_vertices;
        if (pt.last)
            frame_vertices = '0;
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input longint expected,
                                          input longint actual);
        if (expected != actual)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
        end
    endfunction

    // Predict on every particle transaction.
    always @(posedge clk)
    begin
        particle_t pt;
        vertex_t   vx;

        if (rst_n && particle_ch.valid && particle_ch.ready)
        begin
            pt.pos_x = particle_ch.pos_x_in;
            pt.pos_y = particle_ch.pos_y_in;
            pt.hue = particle_ch.hue;
            pt.life = particle_ch.life;
            pt.last = particle_ch.last_particle;
            if (shade_particle(pt, vx))
                expected_vertices.push_back(vx);
        end
    end

    // Check every vertex transaction against the oldest prediction.
    always @(posedge clk)
    begin
        vertex_t vx;

        if (rst_n && vertex_ch.valid && vertex_ch.ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected vertex, expected none, actual x=%0d y=%0d", $time,
                         vertex_ch.pos_x_out, vertex_ch.pos_y_out);
            end
            else
            begin
                vx = expected_vertices.pop_front();
                compare_field("pos_x_out", vx.pos_x, vertex_ch.pos_x_out);
                compare_field("pos_y_out", vx.pos_y, vertex_ch.pos_y_out);
                compare_field("red", vx.red, vertex_ch.red);
                compare_field("green", vx.green, vertex_ch.green);
                compare_field("blue", vx.blue, vertex_ch.blue);
                compare_field("alpha", vx.alpha, vertex_ch.alpha);
                compare_field("last_vertex", vx.last, vertex_ch.last_vertex);
                compare_field("vertices_written", vx.written, vertex_ch.vertices_written);
            end
        end
    end

    always @(posedge clk)
        vertex_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (particle_ch.valid && particle_ch.ready) ||
            (vertex_ch.valid && vertex_ch.ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_particle(input particle_t pt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            particle_ch.valid <= 1'b0;
            @(posedge clk);
        end
        particle_ch.valid <= 1'b1;
        particle_ch.pos_x_in <= pt.pos_x;
        particle_ch.pos_y_in <= pt.pos_y;
        particle_ch.hue <= pt.hue;
        particle_ch.life <= pt.life;
        particle_ch.last_particle <= pt.last;
        do
        begin
            @(posedge clk);
        end
        while (!particle_ch.ready);
    endtask

    task automatic send_fields(input int x, input int y, input int hue, input int life,
                               input bit last);
        particle_t pt;

        pt.pos_x = POS_W'(x);
        pt.pos_y = POS_W'(y);
        pt.hue = COL_W'(hue);
        pt.life = COL_W'(life);
        pt.last = last;
        send_particle(pt);
    endtask

    // Hold off until every vertex is out and a dropped particle has cleared the pipe.
    task automatic wait_idle();
        particle_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_vertices.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write vertex_limit, then read it straight back.
    task automatic write_vertex_limit(input logic [CNT_W-1:0] limit);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_VERTEX_LIMIT, 2'b00};
        pwdata <= APB_DW'(limit);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        vertex_limit_mirror = limit;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        compare_field("vertex_limit readback", limit, prdata[CNT_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic particle_t random_particle(input bit last);
        particle_t pt;

        pt.pos_x = POS_W'($urandom());
        pt.pos_y = POS_W'($urandom());
        if ($urandom_range(9) == 0)
            pt.pos_x = {1'b1, {(POS_W-1){1'b0}}};
        if ($urandom_range(9) == 0)
            pt.pos_y = {1'b0, {(POS_W-1){1'b1}}};
        pt.hue = COL_W'($urandom());
        pt.life = ($urandom_range(4) == 0) ? COL_W'($urandom_range(65535))
                                           : COL_W'($urandom_range(Q15_ONE));
        pt.last = last;
        return pt;
    endfunction

    task automatic test_color_extremes();
        send_fields(-8388608, -8388608, 0, 32768, 1'b0);
        send_fields(8388607, 8388607, 65535, 0, 1'b0);
        send_fields(0, -1, 10923, 32768, 1'b0);
        send_fields(-1, 0, 21845, 20000, 1'b0);
        send_fields(256, -256, 32768, 23405, 1'b0);
        send_fields(1, 2, 43691, 23406, 1'b0);
        send_fields(-2, 3, 54613, 23407, 1'b0);
        send_fields(100, 200, 10922, 32769, 1'b0);
        send_fields(4660, 22136, 43690, 65535, 1'b0);
        send_fields(-4660, -22136, 60000, 1, 1'b0);
        send_fields(0, 0, 32767, 16384, 1'b0);
        send_fields(12345, -54321, 5000, 30000, 1'b1);
        wait_idle();
    endtask

    task automatic test_vertex_limit();
        write_vertex_limit('0);
        send_fields(10, 20, 1000, 32768, 1'b0);
        send_fields(30, 40, 2000, 32768, 1'b1);
        wait_idle();
        write_vertex_limit(CNT_W'(2));
        send_fields(1, 1, 3000, 10000, 1'b0);
        send_fields(2, 2, 4000, 11000, 1'b0);
        send_fields(3, 3, 5000, 12000, 1'b0);
        send_fields(4, 4, 6000, 13000, 1'b1);
        send_fields(5, 5, 7000, 14000, 1'b1);
        wait_idle();
        write_vertex_limit({CNT_W{1'b1}});
        send_fields(6, 6, 8000, 15000, 1'b0);
        send_fields(7, 7, 9000, 16000, 1'b0);
        send_fields(8, 8, 50000, 17000, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int idle_pct[4]  = '{0, 73, 0, 37};
        int stall_pct[4] = '{0, 0, 73, 37};
        int frame_left;
        logic [CNT_W-1:0] limit;

        frame_left = 0;
        for (int round = 0; round < 8; round++)
        begin
            case (round)
                1:       limit = {CNT_W{1'b1}};
                2:       limit = '0;
                3:       limit = CNT_W'($urandom());
                4:       limit = LIMIT_RESET;
                6:       limit = CNT_W'(1);
                default: limit = CNT_W'($urandom_range(1, 24));
            endcase
            write_vertex_limit(limit);
            sender_idle_pct = idle_pct[round % 4];
            receiver_stall_pct = stall_pct[round % 4];
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
                frame_left--;
                send_particle(random_particle(frame_left == 0));
            end
            wait_idle();
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        particle_ch.valid <= 1'b0;
        particle_ch.pos_x_in <= '0;
        particle_ch.pos_y_in <= '0;
        particle_ch.hue <= '0;
        particle_ch.life <= '0;
        particle_ch.last_particle <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_color_extremes();
        test_vertex_limit();
        test_random_traffic();

        if (mismatch_count == 0 && expected_vertices.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
